[sv/mesh_ogm_route_engine_top_defines.svh]
`ifndef MESH_OGM_ROUTE_ENGINE_TOP_DEFINES_SVH
`define MESH_OGM_ROUTE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MOGM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MOGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mogm_pkg.sv]
package mogm_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ADDRESS     = 8'd0,
    CFG_INITIAL_TTL      = 8'd1,
    CFG_PURGE_TIMEOUT    = 8'd2,
    CFG_PROTOCOL_VERSION = 8'd3
  } cfg_reg_t;

  localparam logic [7:0]  NODE_ADDRESS_RST     = 8'd1;
  localparam logic [7:0]  INITIAL_TTL_RST      = 8'd5;
  localparam logic [15:0] PURGE_TIMEOUT_RST    = 16'd10;
  localparam logic [7:0]  PROTOCOL_VERSION_RST = 8'd1;

  localparam logic ACT_MSG  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam int FLAG_DIRECT_BIT = 0;
  localparam int FLAG_UNIDIR_BIT = 1;

  typedef struct packed {
    logic        action;
    logic [7:0]  msg_version;
    logic [7:0]  msg_flags;
    logic [7:0]  msg_ttl;
    logic [15:0] msg_sequence;
    logic [7:0]  msg_originator;
    logic [7:0]  msg_sender;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_version;
    logic [7:0]  out_flags;
    logic [7:0]  out_ttl;
    logic [15:0] out_sequence;
    logic [7:0]  out_originator;
    logic [7:0]  out_sender;
    logic        out_is_forward;
  } out_result_t;

  typedef struct packed {
    logic [15:0] stamp;
    logic [7:0]  gateway;
    logic [7:0]  target;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  typedef enum logic [1:0] {
    REC_NONE,
    REC_IF_KNOWN,
    REC_IF_UNKNOWN
  } rec_mode_t;

  typedef enum logic {
    OP_PURGE,
    OP_LOOKUP
  } scan_op_t;

  typedef struct packed {
    logic        valid;
    scan_op_t    op;
    rec_mode_t   rec;
    logic [7:0]  target;
    logic [7:0]  gateway;
    logic [15:0] now;
    logic [15:0] timeout;
  } tbl_req_t;

  typedef struct packed {
    logic done;
    logic known;
  } tbl_rsp_t;

endpackage

[sv/mesh_ogm_route_engine_top.sv]
// tick: own message on out_strobe the cycle after start, then busy for the purge
// pass, which reads the whole route table (one route table read per cycle)
// received message: rejected or dropped items never make the block busy;
// checked items keep it busy for a table scan plus write-back
// one item at a time; results are not held off by the receiver
// rst_n is synchronous: route table emptied, counters zeroed, registers to defaults
module mesh_ogm_route_engine_top import mogm_pkg::*; #(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_result_t           out_result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {
    T_IDLE,
    T_WAIT
  } ctl_state_t;

  ctl_state_t  ctl_r;
  logic [7:0]  node_address_r;
  logic [7:0]  initial_ttl_r;
  logic [15:0] purge_timeout_r;
  logic [7:0]  protocol_version_r;
  logic [15:0] tick_time_r;
  logic [15:0] own_seq_r;
  logic        fwd_r;
  tbl_req_t    req_r;
  tbl_rsp_t    rsp;
  logic        out_strobe_r;
  out_result_t out_result_r;

  logic       accept;
  logic       msg_ok;
  logic       is_echo;
  logic       dir_flag;
  logic       uni_flag;
  logic [7:0] fwd_flags;

  assign busy     = (ctl_r != T_IDLE);
  assign accept   = start && !busy;
  assign msg_ok   = (in_item.msg_version == protocol_version_r) &&
                    (in_item.msg_sender != node_address_r) &&
                    (in_item.msg_ttl != 8'd0);
  assign is_echo  = (in_item.msg_originator == node_address_r);
  assign dir_flag = in_item.msg_flags[FLAG_DIRECT_BIT];
  assign uni_flag = in_item.msg_flags[FLAG_UNIDIR_BIT];

  // unidirectional bit filled in once the gateway lookup is back
  always_comb begin
    fwd_flags = '0;
    fwd_flags[FLAG_DIRECT_BIT] = (in_item.msg_sender == in_item.msg_originator);
  end

  mogm_route_table #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r              <= T_IDLE;
      node_address_r     <= NODE_ADDRESS_RST;
      initial_ttl_r      <= INITIAL_TTL_RST;
      purge_timeout_r    <= PURGE_TIMEOUT_RST;
      protocol_version_r <= PROTOCOL_VERSION_RST;
      tick_time_r        <= '0;
      own_seq_r          <= '0;
      fwd_r              <= 1'b0;
      req_r.valid        <= 1'b0;
      out_strobe_r       <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      req_r.valid  <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_ADDRESS:     node_address_r     <= cfg_data[7:0];
          CFG_INITIAL_TTL:      initial_ttl_r      <= cfg_data[7:0];
          CFG_PURGE_TIMEOUT:    purge_timeout_r    <= cfg_data;
          CFG_PROTOCOL_VERSION: protocol_version_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      case (ctl_r)
        T_IDLE: begin
          if (accept) begin
            if (in_item.action == ACT_TICK) begin
              tick_time_r   <= tick_time_r + 16'd1;
              own_seq_r     <= own_seq_r + 16'd1;
              out_strobe_r  <= 1'b1;
              out_result_r  <= '{out_version: protocol_version_r, out_flags: 8'd0,
                                 out_ttl: initial_ttl_r, out_sequence: own_seq_r,
                                 out_originator: node_address_r,
                                 out_sender: node_address_r, out_is_forward: 1'b0};
              req_r.valid   <= 1'b1;
              req_r.op      <= OP_PURGE;
              req_r.rec     <= REC_NONE;
              req_r.now     <= tick_time_r + 16'd1;
              req_r.timeout <= purge_timeout_r;
              fwd_r         <= 1'b0;
              ctl_r         <= T_WAIT;
            end else if (msg_ok) begin
              if (is_echo) begin
                // own message echoed back: maybe learn the neighbor
                if (dir_flag) begin
                  req_r.valid   <= 1'b1;
                  req_r.op      <= OP_LOOKUP;
                  req_r.rec     <= REC_IF_UNKNOWN;
                  req_r.target  <= in_item.msg_sender;
                  req_r.gateway <= in_item.msg_sender;
                  req_r.now     <= tick_time_r;
                  fwd_r         <= 1'b0;
                  ctl_r         <= T_WAIT;
                end
              end else if (!uni_flag) begin
                req_r.valid   <= 1'b1;
                req_r.op      <= OP_LOOKUP;
                req_r.rec     <= REC_IF_KNOWN;
                req_r.target  <= in_item.msg_originator;
                req_r.gateway <= in_item.msg_sender;
                req_r.now     <= tick_time_r;
                fwd_r         <= 1'b1;
                out_result_r  <= '{out_version: in_item.msg_version, out_flags: fwd_flags,
                                   out_ttl: in_item.msg_ttl - 8'd1,
                                   out_sequence: in_item.msg_sequence,
                                   out_originator: in_item.msg_originator,
                                   out_sender: node_address_r, out_is_forward: 1'b1};
                ctl_r         <= T_WAIT;
              end
            end
          end
        end
        T_WAIT: begin
          if (rsp.done) begin
            if (fwd_r) begin
              out_strobe_r <= 1'b1;
              out_result_r.out_flags[FLAG_UNIDIR_BIT] <= !rsp.known;
            end
            ctl_r <= T_IDLE;
          end
        end
        default: begin
          ctl_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

[sv/mogm_ram.sv]
module mogm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/mogm_route_table.sv]
module mogm_route_table import mogm_pkg::*; #(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ROUTE_ENTRIES - 1);
  localparam logic [CW-1:0] N_CNT    = CW'(ROUTE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } tbl_state_t;

  tbl_state_t   state_r;
  scan_op_t     op_r;
  rec_mode_t    rec_r;
  logic [7:0]   target_r;
  logic [7:0]   gateway_r;
  logic [15:0]  now_r;
  logic [15:0]  timeout_r;

  logic [CW-1:0] rd_cnt_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic [ROUTE_ENTRIES-1:0] valid_r;

  logic          known_r;
  logic          match_fnd_r;
  logic [IW-1:0] match_idx_r;
  logic          free_fnd_r;
  logic [IW-1:0] free_idx_r;
  logic          done_r;

  logic [ENTRY_W-1:0] ram_rdata;
  route_entry_t       ent;
  logic               ent_vld;
  logic [15:0]        age;
  logic               stale;
  logic               gw_hit;
  logic               pair_hit;
  logic               free_hit;
  logic               rd_issue;
  logic [IW-1:0]      rd_addr;
  logic               scan_end;
  logic               do_rec;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  route_entry_t       wr_ent;

  assign ent      = route_entry_t'(ram_rdata);
  assign ent_vld  = cmp_vld_r && valid_r[cmp_idx_r];
  // age wraps like the 16-bit tick counter
  assign age      = now_r - ent.stamp;
  assign stale    = ent_vld && (age > timeout_r);
  assign gw_hit   = ent_vld && (ent.gateway == gateway_r);
  assign pair_hit = gw_hit && (ent.target == target_r);
  assign free_hit = cmp_vld_r && !valid_r[cmp_idx_r];

  assign rd_issue = (state_r == S_SCAN) && (rd_cnt_r != N_CNT);
  assign rd_addr  = rd_cnt_r[IW-1:0];
  assign scan_end = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  assign do_rec = ((rec_r == REC_IF_KNOWN) && known_r) ||
                  ((rec_r == REC_IF_UNKNOWN) && !known_r);
  assign wr_en   = (state_r == S_WRITE) && do_rec && (match_fnd_r || free_fnd_r);
  assign wr_addr = match_fnd_r ? match_idx_r : free_idx_r;
  assign wr_ent  = '{stamp: now_r, gateway: gateway_r, target: target_r};

  mogm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROUTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
      rd_cnt_r  <= '0;
      done_r    <= 1'b0;
    end else begin
      done_r    <= 1'b0;
      cmp_vld_r <= rd_issue;
      cmp_idx_r <= rd_addr;
      if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
      end

      case (state_r)
        S_IDLE: begin
          if (req.valid) begin
            op_r        <= req.op;
            rec_r       <= req.rec;
            target_r    <= req.target;
            gateway_r   <= req.gateway;
            now_r       <= req.now;
            timeout_r   <= req.timeout;
            rd_cnt_r    <= '0;
            known_r     <= 1'b0;
            match_fnd_r <= 1'b0;
            free_fnd_r  <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (op_r == OP_PURGE) begin
            if (stale) begin
              valid_r[cmp_idx_r] <= 1'b0;
            end
          end else begin
            if (gw_hit) begin
              known_r <= 1'b1;
            end
            if (pair_hit && !match_fnd_r) begin
              match_fnd_r <= 1'b1;
              match_idx_r <= cmp_idx_r;
            end
            // lowest free slot wins
            if (free_hit && !free_fnd_r) begin
              free_fnd_r <= 1'b1;
              free_idx_r <= cmp_idx_r;
            end
          end
          if (scan_end) begin
            if (op_r == OP_PURGE) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (wr_en && !match_fnd_r) begin
            valid_r[wr_addr] <= 1'b1;
          end
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.known = known_r;

endmodule

[sv/mogm_checker.sv]
`include "mesh_ogm_route_engine_top_defines.svh"

module mogm_checker import mogm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input in_item_t    in_item,
  input logic        out_strobe,
  input out_result_t out_result
);

  `MOGM_ASSERT_NEXT(a_tick_result, start && !busy && in_item.action == ACT_TICK, out_strobe && !out_result.out_is_forward, "tick item gave no own message")
  `MOGM_ASSERT_NEXT(a_tick_busy, start && !busy && in_item.action == ACT_TICK, busy, "no purge pass after tick")
  `MOGM_ASSERT_SAME(a_own_during_purge, out_strobe && !out_result.out_is_forward, busy, "own message outside purge pass")
  `MOGM_ASSERT_SAME(a_fwd_ttl, out_strobe && out_result.out_is_forward, out_result.out_ttl != 8'hff, "forwarded ttl wrapped")

endmodule

bind mesh_ogm_route_engine_top mogm_checker u_mogm_checker (.*);
